// ===== rtl/bgr_pkg.sv =====
// Shared types and constants for the bilinear grid resampler.
`default_nettype none
package bgr_pkg;

  localparam int unsigned DEF_MAX_GRID_COLUMNS   = 256;
  localparam int unsigned DEF_MAX_GRID_ROWS      = 256;
  localparam int unsigned DEF_MAX_OUTPUT_COLUMNS = 4096;

  localparam int unsigned STORE_AW    = 16;
  localparam int unsigned QUEUE_DEPTH = 4;

  localparam logic [31:0] RST_X_ORIGIN  = 32'h0000_8000;
  localparam logic [31:0] RST_X_STEP    = 32'h0001_0000;
  localparam logic [31:0] RST_Y_ORIGIN  = 32'h0000_8000;
  localparam logic [31:0] RST_Y_STEP    = 32'h0001_0000;
  localparam logic [8:0]  RST_GRID_COLS = 9'd256;
  localparam logic [8:0]  RST_GRID_ROWS = 9'd256;
  localparam logic [31:0] RST_NODATA    = 32'hFFD8_F000;
  localparam logic [12:0] RST_OUT_COLS  = 13'd4096;

  typedef enum logic [2:0] {
    REG_X_ORIGIN  = 3'd0,
    REG_X_STEP    = 3'd1,
    REG_Y_ORIGIN  = 3'd2,
    REG_Y_STEP    = 3'd3,
    REG_GRID_COLS = 3'd4,
    REG_GRID_ROWS = 3'd5,
    REG_NODATA    = 3'd6,
    REG_OUT_COLS  = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_NODATA  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_RD1,
    SQ_RD2,
    SQ_RD3,
    SQ_DONE
  } seq_state_e;

  // Classified work item passed from the front to the back.
  typedef struct packed {
    logic                is_load;
    logic                outside;
    logic [STORE_AW-1:0] addr;
    logic [31:0]         data;
    logic [15:0]         fx;
    logic [15:0]         fy;
    logic [23:0]         oidx;
  } entry_t;

  // Four corners and blend weights of one query.
  typedef struct packed {
    logic [31:0] q11;
    logic [31:0] q21;
    logic [31:0] q12;
    logic [31:0] q22;
    logic [15:0] fx;
    logic [15:0] fy;
    logic [23:0] oidx;
    logic        outside;
  } corner_t;

endpackage
`default_nettype wire

// ===== rtl/bgr_front.sv =====
// Front end: accepts items, maps queries to grid coordinates and classifies them.
`default_nettype none
module bgr_front #(
  parameter int unsigned MAX_GRID_COLUMNS   = bgr_pkg::DEF_MAX_GRID_COLUMNS,
  parameter int unsigned MAX_GRID_ROWS      = bgr_pkg::DEF_MAX_GRID_ROWS,
  parameter int unsigned MAX_OUTPUT_COLUMNS = bgr_pkg::DEF_MAX_OUTPUT_COLUMNS,
  localparam int unsigned CW  = $clog2(MAX_GRID_COLUMNS + 1),
  localparam int unsigned RW  = $clog2(MAX_GRID_ROWS + 1),
  localparam int unsigned OCW = $clog2(MAX_OUTPUT_COLUMNS + 1)
) (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire                  kind_i,
  input  wire  [15:0]          cell_index_i,
  input  wire  signed [31:0]   sample_value_i,
  input  wire  [11:0]          point_col_i,
  input  wire  [11:0]          point_row_i,
  input  wire  signed [31:0]   x_origin_i,
  input  wire  signed [31:0]   x_step_i,
  input  wire  signed [31:0]   y_origin_i,
  input  wire  signed [31:0]   y_step_i,
  input  wire  [CW-1:0]        cols_i,
  input  wire  [RW-1:0]        rows_i,
  input  wire  [OCW-1:0]       ocols_i,
  output logic                 push_valid_o,
  input  wire                  push_ready_i,
  output bgr_pkg::entry_t      push_entry_o
);
  import bgr_pkg::*;

  localparam int unsigned IW  = $clog2(MAX_GRID_COLUMNS);
  localparam int unsigned JW  = $clog2(MAX_GRID_ROWS);
  localparam int unsigned OIW = 12 + OCW + 1;

  logic               f1_v_q;
  logic               is_load_q;
  logic [15:0]        cell_q;
  logic [31:0]        sample_q;
  logic signed [45:0] xs_q, ys_q;
  logic [23:0]        oidx_q;

  logic signed [44:0] xp, yp;
  logic signed [45:0] xs_d, ys_d;
  logic [OIW-1:0]     oprod;
  logic               accept;
  logic               in_x, in_y;
  logic [IW-1:0]      ci;
  logic [JW-1:0]      cj;
  logic [15:0]        base;

  assign in_stall_o = f1_v_q && !push_ready_i;
  assign accept     = in_valid_i && !in_stall_o;

  assign xp    = $signed({1'b0, point_col_i}) * x_step_i;
  assign yp    = $signed({1'b0, point_row_i}) * y_step_i;
  assign xs_d  = {xp[44], xp} + {{14{x_origin_i[31]}}, x_origin_i};
  assign ys_d  = {yp[44], yp} + {{14{y_origin_i[31]}}, y_origin_i};
  assign oprod = OIW'(point_row_i) * OIW'(ocols_i) + OIW'(point_col_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      f1_v_q <= 1'b0;
    end else if (!in_stall_o) begin
      f1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      is_load_q <= ~kind_i;
      cell_q    <= cell_index_i;
      sample_q  <= sample_value_i;
      xs_q      <= xs_d;
      ys_q      <= ys_d;
      oidx_q    <= 24'(oprod);
    end
  end

  // Inside test against (size - 1) in Q16.16
  assign in_x = !xs_q[45] && (xs_q[44:0] < 45'({cols_i - CW'(1), 16'h0000}));
  assign in_y = !ys_q[45] && (ys_q[44:0] < 45'({rows_i - RW'(1), 16'h0000}));
  assign ci   = xs_q[16 +: IW];
  assign cj   = ys_q[16 +: JW];
  assign base = 16'(32'(cj) * 32'(cols_i) + 32'(ci));

  always_comb begin
    push_valid_o         = f1_v_q;
    push_entry_o.is_load = is_load_q;
    push_entry_o.outside = !(in_x && in_y);
    push_entry_o.addr    = is_load_q ? cell_q : base;
    push_entry_o.data    = sample_q;
    push_entry_o.fx      = xs_q[15:0];
    push_entry_o.fy      = ys_q[15:0];
    push_entry_o.oidx    = oidx_q;
  end

endmodule
`default_nettype wire

// ===== rtl/bgr_queue.sv =====
// Short FIFO between the front end and the back end.
`default_nettype none
module bgr_queue (
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_valid_i,
  output logic             push_ready_o,
  input  bgr_pkg::entry_t  push_entry_i,
  output logic             empty_o,
  input  wire              pop_i,
  output bgr_pkg::entry_t  head_o
);
  import bgr_pkg::*;

  localparam int unsigned QAW = $clog2(QUEUE_DEPTH);

  entry_t       slot_q [QUEUE_DEPTH];
  logic [QAW-1:0] wp_q, rp_q;
  logic [QAW:0]   cnt_q;
  logic           push;

  assign push_ready_o = (cnt_q != (QAW+1)'(QUEUE_DEPTH));
  assign empty_o      = (cnt_q == '0);
  assign push         = push_valid_i && push_ready_o;
  assign head_o       = slot_q[rp_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + QAW'(1);
      if (pop_i) rp_q <= rp_q + QAW'(1);
      cnt_q <= cnt_q + (QAW+1)'(push) - (QAW+1)'(pop_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wp_q] <= push_entry_i;
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bgr_back.sv =====
// Back end: grid store, load writes and the four-read corner sequencer.
`default_nettype none
module bgr_back (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               empty_i,
  input  bgr_pkg::entry_t   head_i,
  output logic              pop_o,
  input  wire  [15:0]       cols_i,
  output logic              cb_valid_o,
  input  wire               cb_ready_i,
  output bgr_pkg::corner_t  cb_o
);
  import bgr_pkg::*;

  logic [31:0] mem [2**STORE_AW];
  logic [31:0] rdata_q;

  seq_state_e          state_q, state_d;
  logic [STORE_AW-1:0] base_q;
  logic [15:0]         fx_q, fy_q;
  logic [23:0]         oidx_q;
  logic [31:0]         c0_q, c1_q, c2_q;

  logic                rd_en, wr_en, meta_ld, dispatch;
  logic [STORE_AW-1:0] rd_addr;

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[head_i.addr] <= head_i.data;
    if (rd_en) rdata_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SQ_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (meta_ld) begin
      base_q <= head_i.addr;
      fx_q   <= head_i.fx;
      fy_q   <= head_i.fy;
      oidx_q <= head_i.oidx;
    end
    if (state_q == SQ_RD1) c0_q <= rdata_q;
    if (state_q == SQ_RD2) c1_q <= rdata_q;
    if (state_q == SQ_RD3) c2_q <= rdata_q;
  end

  always_comb begin
    state_d    = state_q;
    rd_en      = 1'b0;
    rd_addr    = head_i.addr;
    wr_en      = 1'b0;
    meta_ld    = 1'b0;
    pop_o      = 1'b0;
    cb_valid_o = 1'b0;
    cb_o       = '{q11: c0_q, q21: c1_q, q12: c2_q, q22: rdata_q,
                   fx: fx_q, fy: fy_q, oidx: oidx_q, outside: 1'b0};
    dispatch   = 1'b0;

    case (state_q)
      SQ_IDLE: dispatch = 1'b1;
      SQ_RD1: begin
        rd_en   = 1'b1;
        rd_addr = base_q + STORE_AW'(1);
        state_d = SQ_RD2;
      end
      SQ_RD2: begin
        rd_en   = 1'b1;
        rd_addr = base_q + cols_i;
        state_d = SQ_RD3;
      end
      SQ_RD3: begin
        rd_en   = 1'b1;
        rd_addr = base_q + cols_i + STORE_AW'(1);
        state_d = SQ_DONE;
      end
      SQ_DONE: begin
        // hold the last corner in the read register until the blend takes it
        if (cb_ready_i) begin
          cb_valid_o = 1'b1;
          state_d    = SQ_IDLE;
          dispatch   = 1'b1;
        end
      end
      default: state_d = SQ_IDLE;
    endcase

    if (dispatch && !empty_i) begin
      if (head_i.is_load) begin
        wr_en = 1'b1;
        pop_o = 1'b1;
      end else if (head_i.outside) begin
        if (state_q == SQ_IDLE && cb_ready_i) begin
          cb_valid_o = 1'b1;
          cb_o.fx      = head_i.fx;
          cb_o.fy      = head_i.fy;
          cb_o.oidx    = head_i.oidx;
          cb_o.outside = 1'b1;
          pop_o        = 1'b1;
        end
      end else begin
        rd_en   = 1'b1;
        meta_ld = 1'b1;
        pop_o   = 1'b1;
        state_d = SQ_RD1;
      end
    end
  end

endmodule
`default_nettype wire

// ===== rtl/bgr_blend.sv =====
// Blend pipeline: nodata check, bilinear weighting, rounding and result register.
`default_nettype none
module bgr_blend (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               cb_valid_i,
  output logic              cb_ready_o,
  input  bgr_pkg::corner_t  cb_i,
  input  wire  [31:0]       nodata_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [23:0]       out_index_o,
  output logic signed [31:0] elevation_out_o,
  output logic [1:0]        status_o
);
  import bgr_pkg::*;

  logic v1_q, v2_q, v3_q, v4_q, ov_q;
  logic r1, r2, r3, r4, ro;

  corner_t            s1_q;
  logic signed [49:0] p1_q, p2_q;
  logic [31:0]        q11_q, q12_q;
  logic [15:0]        fy2_q, fy3_q;
  logic [23:0]        oi2_q, oi3_q, oi4_q;
  status_e            st2_q, st3_q, st4_q;
  logic signed [49:0] r1_q, r1b_q, dd_q;
  logic signed [42:0] mh_q;
  logic [39:0]        ml_q;

  logic               nodata;
  status_e            st1;
  logic signed [32:0] d1, d2;
  logic signed [49:0] p1, p2, ra, rb;
  logic signed [42:0] mh;
  logic [39:0]        ml;
  logic signed [65:0] z;

  assign ro         = !ov_q || !out_stall_i;
  assign r4         = !v4_q || ro;
  assign r3         = !v3_q || r4;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign cb_ready_o = r1;

  assign nodata = (s1_q.q11 == nodata_i) || (s1_q.q21 == nodata_i) ||
                  (s1_q.q12 == nodata_i) || (s1_q.q22 == nodata_i);
  assign st1 = s1_q.outside ? ST_OUTSIDE : (nodata ? ST_NODATA : ST_OK);
  assign d1  = $signed({s1_q.q21[31], s1_q.q21}) - $signed({s1_q.q11[31], s1_q.q11});
  assign d2  = $signed({s1_q.q22[31], s1_q.q22}) - $signed({s1_q.q12[31], s1_q.q12});
  assign p1  = d1 * $signed({1'b0, s1_q.fx});
  assign p2  = d2 * $signed({1'b0, s1_q.fx});

  assign ra = $signed({{2{q11_q[31]}}, q11_q, 16'h0000}) + p1_q;
  assign rb = $signed({{2{q12_q[31]}}, q12_q, 16'h0000}) + p2_q;

  // split the row difference so each product stays narrow
  assign mh = $signed(dd_q[49:24]) * $signed({1'b0, fy3_q});
  assign ml = dd_q[23:0] * fy3_q;

  assign z = $signed({r1b_q, 16'h0000}) + $signed({{23{mh_q[42]}}, mh_q} <<< 24)
           + $signed({26'h0, ml_q}) + 66'sh8000_0000;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      ov_q <= 1'b0;
    end else begin
      if (r1) v1_q <= cb_valid_i;
      if (r2) v2_q <= v1_q;
      if (r3) v3_q <= v2_q;
      if (r4) v4_q <= v3_q;
      if (ro) ov_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r1) s1_q <= cb_i;
    if (r2) begin
      p1_q  <= p1;
      p2_q  <= p2;
      q11_q <= s1_q.q11;
      q12_q <= s1_q.q12;
      fy2_q <= s1_q.fy;
      oi2_q <= s1_q.oidx;
      st2_q <= st1;
    end
    if (r3) begin
      r1_q  <= ra;
      dd_q  <= rb - ra;
      fy3_q <= fy2_q;
      oi3_q <= oi2_q;
      st3_q <= st2_q;
    end
    if (r4) begin
      r1b_q <= r1_q;
      mh_q  <= mh;
      ml_q  <= ml;
      oi4_q <= oi3_q;
      st4_q <= st3_q;
    end
    if (ro) begin
      out_index_o     <= oi4_q;
      status_o        <= st4_q;
      elevation_out_o <= (st4_q == ST_OK) ? z[63:32] : 32'sd0;
    end
  end

  assign out_valid_o = ov_q;

endmodule
`default_nettype wire

// ===== rtl/bilinear_grid_resampler_top.sv =====
// Top level of the bilinear grid resampler: configuration registers and block wiring.
//
// Load items (kind 0) write one sample into a 65536-entry single-port grid store and
// produce no result; a load is a single store write. Query items (kind 1) produce one
// result each: an outside query reads no corners, an inside query reads its four
// corners one after another on the single store port, so the back end takes no new
// item while those reads run. The front end takes one item per cycle, while not stalled,
// into a four-entry queue, so items are accepted while the back end and the result
// register are busy, until the queue is full. The store has no reset and no
// clearing pass: a cell must be loaded before a query reads it.
`default_nettype none
module bilinear_grid_resampler_top #(
  parameter int unsigned MAX_GRID_COLUMNS   = bgr_pkg::DEF_MAX_GRID_COLUMNS,
  parameter int unsigned MAX_GRID_ROWS      = bgr_pkg::DEF_MAX_GRID_ROWS,
  parameter int unsigned MAX_OUTPUT_COLUMNS = bgr_pkg::DEF_MAX_OUTPUT_COLUMNS
) (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               psel,
  input  wire               penable,
  input  wire               pwrite,
  input  wire  [4:0]        paddr,
  input  wire  [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  input  wire               in_valid_i,
  output logic              in_stall_o,
  input  wire               kind_i,
  input  wire  [15:0]       cell_index_i,
  input  wire  signed [31:0] sample_value_i,
  input  wire  [11:0]       point_col_i,
  input  wire  [11:0]       point_row_i,
  output logic              out_valid_o,
  input  wire               out_stall_i,
  output logic [23:0]       out_index_o,
  output logic signed [31:0] elevation_out_o,
  output logic [1:0]        status_o
);
  import bgr_pkg::*;

  localparam int unsigned CW  = $clog2(MAX_GRID_COLUMNS + 1);
  localparam int unsigned RW  = $clog2(MAX_GRID_ROWS + 1);
  localparam int unsigned OCW = $clog2(MAX_OUTPUT_COLUMNS + 1);

  logic [31:0] x_origin_q, x_step_q, y_origin_q, y_step_q, nodata_q;
  logic [8:0]  gcols_q, grows_q;
  logic [12:0] ocols_q;

  logic [CW-1:0]  cols;
  logic [RW-1:0]  rows;
  logic [OCW-1:0] ocols;
  logic           wr;
  reg_idx_e       idx;

  logic    push_valid, push_ready, empty, pop, cb_valid, cb_ready;
  entry_t  push_entry, head;
  corner_t cb;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign idx    = reg_idx_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x_origin_q <= RST_X_ORIGIN;
      x_step_q   <= RST_X_STEP;
      y_origin_q <= RST_Y_ORIGIN;
      y_step_q   <= RST_Y_STEP;
      gcols_q    <= RST_GRID_COLS;
      grows_q    <= RST_GRID_ROWS;
      nodata_q   <= RST_NODATA;
      ocols_q    <= RST_OUT_COLS;
    end else if (wr) begin
      case (idx)
        REG_X_ORIGIN:  x_origin_q <= pwdata;
        REG_X_STEP:    x_step_q   <= pwdata;
        REG_Y_ORIGIN:  y_origin_q <= pwdata;
        REG_Y_STEP:    y_step_q   <= pwdata;
        REG_GRID_COLS: gcols_q    <= pwdata[8:0];
        REG_GRID_ROWS: grows_q    <= pwdata[8:0];
        REG_NODATA:    nodata_q   <= pwdata;
        REG_OUT_COLS:  ocols_q    <= pwdata[12:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_ORIGIN:  prdata = x_origin_q;
      REG_X_STEP:    prdata = x_step_q;
      REG_Y_ORIGIN:  prdata = y_origin_q;
      REG_Y_STEP:    prdata = y_step_q;
      REG_GRID_COLS: prdata = 32'(gcols_q);
      REG_GRID_ROWS: prdata = 32'(grows_q);
      REG_NODATA:    prdata = nodata_q;
      REG_OUT_COLS:  prdata = 32'(ocols_q);
      default:       prdata = '0;
    endcase
  end

  // Hold grid and output sizes to their legal ranges
  always_comb begin
    if (32'(gcols_q) < 32'd2) cols = CW'(2);
    else if (32'(gcols_q) > MAX_GRID_COLUMNS) cols = CW'(MAX_GRID_COLUMNS);
    else cols = CW'(gcols_q);
    if (32'(grows_q) < 32'd2) rows = RW'(2);
    else if (32'(grows_q) > MAX_GRID_ROWS) rows = RW'(MAX_GRID_ROWS);
    else rows = RW'(grows_q);
    if (32'(ocols_q) < 32'd1) ocols = OCW'(1);
    else if (32'(ocols_q) > MAX_OUTPUT_COLUMNS) ocols = OCW'(MAX_OUTPUT_COLUMNS);
    else ocols = OCW'(ocols_q);
  end

  bgr_front #(
    .MAX_GRID_COLUMNS  (MAX_GRID_COLUMNS),
    .MAX_GRID_ROWS     (MAX_GRID_ROWS),
    .MAX_OUTPUT_COLUMNS(MAX_OUTPUT_COLUMNS)
  ) u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .kind_i        (kind_i),
    .cell_index_i  (cell_index_i),
    .sample_value_i(sample_value_i),
    .point_col_i   (point_col_i),
    .point_row_i   (point_row_i),
    .x_origin_i    (x_origin_q),
    .x_step_i      (x_step_q),
    .y_origin_i    (y_origin_q),
    .y_step_i      (y_step_q),
    .cols_i        (cols),
    .rows_i        (rows),
    .ocols_i       (ocols),
    .push_valid_o  (push_valid),
    .push_ready_i  (push_ready),
    .push_entry_o  (push_entry)
  );

  bgr_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_valid_i(push_valid),
    .push_ready_o(push_ready),
    .push_entry_i(push_entry),
    .empty_o     (empty),
    .pop_i       (pop),
    .head_o      (head)
  );

  bgr_back u_back (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .empty_i   (empty),
    .head_i    (head),
    .pop_o     (pop),
    .cols_i    (16'(cols)),
    .cb_valid_o(cb_valid),
    .cb_ready_i(cb_ready),
    .cb_o      (cb)
  );

  bgr_blend u_blend (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cb_valid_i     (cb_valid),
    .cb_ready_o     (cb_ready),
    .cb_i           (cb),
    .nodata_i       (nodata_q),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .out_index_o    (out_index_o),
    .elevation_out_o(elevation_out_o),
    .status_o       (status_o)
  );

endmodule
`default_nettype wire
